// ===== rtl/core/qenc_pkg.sv =====
// Shared types, codes and constants of the quadrature encoder with button unit.
package qenc_pkg;

  // Button event codes, also the button state encoding
  typedef enum logic [2:0] {
    BTN_OPEN     = 3'd0,
    BTN_HELD     = 3'd1,
    BTN_RELEASED = 3'd2,
    BTN_CLICKED  = 3'd3,
    BTN_DOUBLE   = 3'd4
  } btn_event_e;

  // Configuration register indexes
  localparam logic [2:0] CfgActiveLevel   = 3'd0;
  localparam logic [2:0] CfgFeatureEn     = 3'd1;
  localparam logic [2:0] CfgAccelInc      = 3'd2;
  localparam logic [2:0] CfgAccelDec      = 3'd3;
  localparam logic [2:0] CfgAccelCeil     = 3'd4;
  localparam logic [2:0] CfgDebounceMs    = 3'd5;
  localparam logic [2:0] CfgHoldLimit     = 3'd6;
  localparam logic [2:0] CfgDblClickLimit = 3'd7;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  // Field widths
  localparam int unsigned CountW = 16;
  localparam int unsigned AccelW = 15;
  localparam int unsigned TimeW  = 32;

  // Acceleration decay per tick and the shift applied before scaling
  localparam logic [AccelW-1:0] DecayStep  = 15'd5;
  localparam int unsigned       AccelShift = 4;

  // Stream widths (payload padded to whole bytes)
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  // Quadrature transition table, indexed by {previous phase, current phase}
  localparam logic signed [1:0] StepLut [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0,
    2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1,
    2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

  // Configuration register file contents
  typedef struct packed {
    logic              active_level;
    logic [1:0]        feature_enables;
    logic [AccelW-1:0] accel_increment;
    logic [AccelW-1:0] accel_decrement;
    logic [AccelW-1:0] accel_ceiling;
    logic [7:0]        debounce_ms;
    logic [15:0]       hold_limit;
    logic [15:0]       double_click_limit;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    active_level:       1'b0,
    feature_enables:    2'd0,
    accel_increment:    15'd25,
    accel_decrement:    15'd2,
    accel_ceiling:      15'd3072,
    debounce_ms:        8'd10,
    hold_limit:         16'd100,
    double_click_limit: 16'd60
  };

endpackage

// ===== rtl/core/qenc_quad.sv =====
// Quadrature step decoder, wrapping step count and acceleration with count scaling.
module qenc_quad (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  qenc_pkg::cfg_t               cfg_i,
  input  logic                         a_on_i,
  input  logic                         b_on_i,
  input  logic                         take_value_i,
  output logic [qenc_pkg::CountW-1:0]  scaled_count_o,
  output logic [qenc_pkg::AccelW-1:0]  accel_level_o
);
  import qenc_pkg::*;

  logic [1:0]          prev_q;
  logic [CountW-1:0]   count_q;
  logic [AccelW-1:0]   accel_q;

  logic                accel_on;
  logic [AccelW-1:0]   accel_decayed;
  logic [AccelW-1:0]   accel_bumped;
  logic [AccelW-1:0]   accel_new;
  logic [1:0]          curr;
  logic signed [1:0]   move;
  logic                stepped;
  logic signed [AccelW+1:0] inc_limit;
  logic [CountW-1:0]   count_new;
  logic [11:0]         factor;
  logic [27:0]         product;

  assign accel_on = cfg_i.feature_enables[0];
  assign curr     = {a_on_i, b_on_i};
  assign move     = StepLut[{prev_q, curr}];
  assign stepped  = (move != 2'sd0);

  // Per-tick decay when acceleration is enabled, floored at zero
  assign accel_decayed = !accel_on ? accel_q :
                         (accel_q > cfg_i.accel_decrement) ?
                         accel_q - cfg_i.accel_decrement : '0;

  // Increment only while the sum stays within the ceiling (signed limit)
  assign inc_limit = $signed({2'b00, cfg_i.accel_ceiling})
                   - $signed({2'b00, cfg_i.accel_increment});
  assign accel_bumped = (stepped && accel_on && ($signed({2'b00, accel_decayed}) <= inc_limit))
                      ? accel_decayed + cfg_i.accel_increment : accel_decayed;

  // Fixed decay applied every tick
  assign accel_new = (accel_bumped > DecayStep) ? accel_bumped - DecayStep : '0;

  // Wrapping step count
  assign count_new = !stepped ? count_q :
                     (move > 2'sd0) ? count_q + 16'd1 : count_q - 16'd1;

  // Scale by 1 + accel/16, low 16 bits kept
  assign factor  = 12'd1 + {1'b0, accel_new[AccelW-1:AccelShift]};
  assign product = count_new * factor;

  assign scaled_count_o = accel_on ? product[CountW-1:0] : count_new;
  assign accel_level_o  = accel_new;

  // State update once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      count_q <= '0;
      accel_q <= '0;
    end else if (en_i) begin
      if (stepped) begin
        prev_q <= curr;
      end
      count_q <= take_value_i ? '0 : count_new;
      accel_q <= accel_new;
    end
  end

  // A taken count restarts from zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && take_value_i |=> count_q == '0)
    else $error("step count not cleared after take");

  // Without acceleration the value only decays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !accel_on |=> accel_q <= $past(accel_q))
    else $error("acceleration grew while disabled");

endmodule

// ===== rtl/core/qenc_button.sv =====
// Debounced button sampler and click / double click / hold state machine.
module qenc_button (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  qenc_pkg::cfg_t              cfg_i,
  input  logic                        btn_on_i,
  input  logic [qenc_pkg::TimeW-1:0]  now_ms_i,
  input  logic                        take_button_i,
  output qenc_pkg::btn_event_e        event_o
);
  import qenc_pkg::*;

  logic [TimeW-1:0] last_q;
  logic [15:0]      press_q;
  logic [15:0]      win_q;
  btn_event_e       state_q;

  logic             due;
  logic [TimeW-1:0] elapsed;
  logic [15:0]      press_s;
  logic [15:0]      win_s;
  btn_event_e       st_s;
  btn_event_e       st_n;

  // Debounce interval check on the wrapping timestamp
  assign elapsed = now_ms_i - last_q;
  assign due     = (elapsed >= {24'd0, cfg_i.debounce_ms});

  // Button sample
  always_comb begin
    press_s = press_q;
    win_s   = win_q;
    st_s    = state_q;
    if (due) begin
      if (btn_on_i) begin
        if (press_q != 16'hFFFF) begin
          press_s = press_q + 16'd1;
        end
        if ((press_s > cfg_i.hold_limit) && cfg_i.feature_enables[1]) begin
          st_s = BTN_HELD;
        end
      end else begin
        if (press_q > 16'd1) begin
          if (state_q == BTN_HELD) begin
            st_s  = BTN_RELEASED;
            win_s = '0;
          end else if ((win_q != '0) && (win_q < cfg_i.double_click_limit)) begin
            st_s  = BTN_DOUBLE;
            win_s = '0;
          end else begin
            win_s = cfg_i.double_click_limit;
          end
        end
        press_s = '0;
      end
      // Click window runs down; expiry reports a single click
      if (win_s != '0) begin
        win_s = win_s - 16'd1;
        if (win_s == '0) begin
          st_s = BTN_CLICKED;
        end
      end
    end
  end

  // Taking the event reopens anything but held
  assign st_n    = (take_button_i && (st_s != BTN_HELD) && (st_s != BTN_OPEN)) ? BTN_OPEN : st_s;
  assign event_o = st_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      press_q <= '0;
      win_q   <= '0;
      state_q <= BTN_OPEN;
    end else if (en_i) begin
      if (due) begin
        last_q <= now_ms_i;
      end
      press_q <= press_s;
      win_q   <= win_s;
      state_q <= st_n;
    end
  end

  // A taken event that is not held leaves the state open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && take_button_i && (st_s != BTN_HELD) |=> state_q == BTN_OPEN)
    else $error("button event not consumed");

  // Between samples the button counters do not move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !due |=> $stable(press_q) && $stable(win_q) && $stable(last_q))
    else $error("button state moved outside a sample");

endmodule

// ===== rtl/core/quadrature_encoder_with_button_unit.sv =====
// Top level of the quadrature encoder with button unit: ports, config registers, pipeline.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+-----------------------------------------
//  s_axis   | in        | tvalid / tready      | tdata: a, b, button, now_ms, take flags
//  m_axis   | out       | tvalid / tready      | tdata: scaled_count, button_event, accel
//  cfg      | in        | cfg_valid / cfg_ready| cfg_index_i (3 b), cfg_data_i (16 b)
//
//  One transaction per clock sustained while the output is not stalled; a tick goes
//  through the input register, then one update pass into the result register.
//  Reset clears all but the payload registers and loads register defaults.
//  The config port is always ready. A stalled output holds the result register; the input
//  register still takes a new transaction in the cycle the result is taken.
module quadrature_encoder_with_button_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] phase_a, [1] phase_b, [2] button_pin, [34:3] now_ms, [35] take_value,
  // [36] take_button, [39:37] zero
  input  logic [qenc_pkg::InDataW-1:0]  s_axis_tdata,
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] scaled_count, [18:16] button_event, [33:19] accel_level, [39:34] zero
  output logic [qenc_pkg::OutDataW-1:0] m_axis_tdata,
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [qenc_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [qenc_pkg::CfgDataW-1:0] cfg_data_i
);
  import qenc_pkg::*;

  cfg_t                cfg_q;
  logic                in_valid_q;
  logic [36:0]         in_data_q;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic                advance;
  logic                lvl;
  logic                a_on;
  logic                b_on;
  logic                btn_on;
  logic [CountW-1:0]   scaled_count;
  logic [AccelW-1:0]   accel_level;
  btn_event_e          button_event;

  // Configuration register file
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgActiveLevel:   cfg_q.active_level       <= cfg_data_i[0];
        CfgFeatureEn:     cfg_q.feature_enables    <= cfg_data_i[1:0];
        CfgAccelInc:      cfg_q.accel_increment    <= cfg_data_i[AccelW-1:0];
        CfgAccelDec:      cfg_q.accel_decrement    <= cfg_data_i[AccelW-1:0];
        CfgAccelCeil:     cfg_q.accel_ceiling      <= cfg_data_i[AccelW-1:0];
        CfgDebounceMs:    cfg_q.debounce_ms        <= cfg_data_i[7:0];
        CfgHoldLimit:     cfg_q.hold_limit         <= cfg_data_i;
        CfgDblClickLimit: cfg_q.double_click_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: the update pass runs when the result register can take it
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata[36:0];
    end
    if (advance) begin
      out_data_q <= {6'd0, accel_level, logic'(button_event[2]), button_event[1:0],
                     scaled_count};
    end
  end

  // Pins compared with the active level
  assign lvl    = cfg_q.active_level;
  assign a_on   = (in_data_q[0] == lvl);
  assign b_on   = (in_data_q[1] == lvl);
  assign btn_on = (in_data_q[2] == lvl);

  qenc_quad u_quad (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (advance),
    .cfg_i          (cfg_q),
    .a_on_i         (a_on),
    .b_on_i         (b_on),
    .take_value_i   (in_data_q[35]),
    .scaled_count_o (scaled_count),
    .accel_level_o  (accel_level)
  );

  qenc_button u_button (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .cfg_i         (cfg_q),
    .btn_on_i      (btn_on),
    .now_ms_i      (in_data_q[34:3]),
    .take_button_i (in_data_q[36]),
    .event_o       (button_event)
  );

  // Every update pass leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("update pass produced no result");

  // A pending tick waits in the input register while the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_data_q))
    else $error("pending tick lost during stall");

endmodule
